FILE: sv/dh_joint_transform_defines.svh
// Assertion macros shared by the dh_joint_transform RTL
`ifndef DH_JOINT_TRANSFORM_DEFINES_SVH
`define DH_JOINT_TRANSFORM_DEFINES_SVH
// implication held at every clock edge outside reset
`define DHJ_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
// next-cycle implication
`define DHJ_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

FILE: sv/dhj_pkg.sv
// Package: types, constants and helpers of the DH joint transform
`default_nettype none
package dhj_pkg;
  localparam int JOINT_CNT_DEF     = 8;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;
  localparam int PI_Q13            = 25736;
  localparam int HALF_PI_Q13       = 12868;
  localparam int CORDIC_GAIN       = 652032874;
  localparam int ONE_Q14           = 16384;
  localparam int XW                = 34;   // CORDIC x/y/z width

  localparam logic FUNC_COMPUTE = 1'b0;
  localparam logic FUNC_LOAD    = 1'b1;

  typedef struct packed {
    logic               func;
    logic [2:0]         joint;
    logic signed [15:0] position;
    logic signed [15:0] angle_offset;
    logic signed [15:0] twist;
    logic signed [23:0] link_offset;
    logic signed [23:0] link_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         joint_out;
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic signed [23:0] tz;
  } out_item_t;

  // data passed down the cell chain alongside the CORDIC state
  typedef struct packed {
    logic               vld;
    logic               func;
    logic [2:0]         joint;
    logic               neg;
    logic signed [15:0] offset;
    logic signed [15:0] ca;
    logic signed [15:0] sa;
    logic signed [23:0] d;
    logic signed [23:0] a;
  } tag_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
  } cord_t;

  function automatic logic signed [XW-1:0] atan_val(input int i);
    logic signed [XW-1:0] v;
    unique case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      default: v = 34'sd128;
    endcase
    return v;
  endfunction

  // round a Q1.14 product and saturate to [-1, 1]
  function automatic logic signed [15:0] rnd_q14(input logic signed [32:0] p);
    logic signed [32:0] r;
    r = (p + 33'sd8192) >>> 14;
    if (r > 33'sd16384) return 16'sd16384;
    if (r < -33'sd16384) return -16'sd16384;
    return r[15:0];
  endfunction
endpackage
`default_nettype wire

FILE: sv/dhj_cell.sv
// One CORDIC rotation cell of the chain
`default_nettype none
module dhj_cell #(
  parameter int STAGE = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  dhj_pkg::cord_t     c_in,
  input  dhj_pkg::tag_t      t_in,
  output dhj_pkg::cord_t     c_out,
  output dhj_pkg::tag_t      t_out
);
  dhj_pkg::cord_t c_r, c_nxt;
  dhj_pkg::tag_t  t_r;
  logic signed [dhj_pkg::XW-1:0] dx, dy;

  always_comb begin
    dx = c_in.y >>> STAGE;
    dy = c_in.x >>> STAGE;
    if (!c_in.z[dhj_pkg::XW-1]) begin
      c_nxt.x = c_in.x - dx;
      c_nxt.y = c_in.y + dy;
      c_nxt.z = c_in.z - dhj_pkg::atan_val(STAGE);
    end else begin
      c_nxt.x = c_in.x + dx;
      c_nxt.y = c_in.y - dy;
      c_nxt.z = c_in.z + dhj_pkg::atan_val(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r.vld <= 1'b0;
    end else if (en) begin
      t_r <= t_in;
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;
  assign t_out = t_r;
endmodule
`default_nettype wire

FILE: sv/dhj_sincos.sv
// Angle wrap, fold and CORDIC cell chain with output rounding
`default_nettype none
module dhj_sincos #(
  parameter int CORDIC_STAGES = dhj_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic signed [16:0] ang,
  input  dhj_pkg::tag_t      t_in,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q,
  output dhj_pkg::tag_t      t_out
);
  localparam int XW = dhj_pkg::XW;
  dhj_pkg::cord_t c [CORDIC_STAGES+1];
  dhj_pkg::tag_t  t [CORDIC_STAGES+1];
  dhj_pkg::cord_t c_first;
  dhj_pkg::tag_t  t_first;
  logic signed [17:0] w;
  logic               neg;
  logic signed [XW-1:0] xr, yr, xs, ys;

  always_comb begin
    w = {ang[16], ang};
    if (w >= 18'(dhj_pkg::PI_Q13)) w = w - 18'(2 * dhj_pkg::PI_Q13);
    else if (w < -18'(dhj_pkg::PI_Q13)) w = w + 18'(2 * dhj_pkg::PI_Q13);
    if (w >= 18'(dhj_pkg::PI_Q13)) w = w - 18'(2 * dhj_pkg::PI_Q13);
    else if (w < -18'(dhj_pkg::PI_Q13)) w = w + 18'(2 * dhj_pkg::PI_Q13);
    neg = 1'b0;
    if (w > 18'(dhj_pkg::HALF_PI_Q13)) begin
      w = w - 18'(dhj_pkg::PI_Q13);
      neg = 1'b1;
    end else if (w < -18'(dhj_pkg::HALF_PI_Q13)) begin
      w = w + 18'(dhj_pkg::PI_Q13);
      neg = 1'b1;
    end
    c_first.x = XW'(dhj_pkg::CORDIC_GAIN);
    c_first.y = '0;
    // folded angle fits 17 bits; scale by 2^17
    c_first.z = {w[XW-18:0], 17'd0};
    t_first = t_in;
    t_first.neg = neg;
  end

  assign c[0] = c_first;
  assign t[0] = t_first;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    dhj_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .c_in(c[i]), .t_in(t[i]), .c_out(c[i+1]), .t_out(t[i+1])
    );
  end

  always_comb begin
    xr = (c[CORDIC_STAGES].x + XW'(32768)) >>> 16;
    yr = (c[CORDIC_STAGES].y + XW'(32768)) >>> 16;
    xs = (xr > XW'(dhj_pkg::ONE_Q14)) ? XW'(dhj_pkg::ONE_Q14) :
         (xr < -XW'(dhj_pkg::ONE_Q14)) ? -XW'(dhj_pkg::ONE_Q14) : xr;
    ys = (yr > XW'(dhj_pkg::ONE_Q14)) ? XW'(dhj_pkg::ONE_Q14) :
         (yr < -XW'(dhj_pkg::ONE_Q14)) ? -XW'(dhj_pkg::ONE_Q14) : yr;
    if (t[CORDIC_STAGES].neg) begin
      xs = -xs;
      ys = -ys;
    end
    cos_q = xs[15:0];
    sin_q = ys[15:0];
  end
  assign t_out = t[CORDIC_STAGES];
endmodule
`default_nettype wire

FILE: sv/dh_joint_transform.sv
// Top level: DH joint transform, table, two CORDIC chains and product stage
// Channel | dir | payload            | handshake
// in      | in  | dhj_pkg::in_item_t  | in_valid / in_stall
// out     | out | dhj_pkg::out_item_t | out_valid / out_stall
// One transaction per cycle unless out_stall freezes the pipeline. A compute
// passes the table read, the cell chain, product stage and output register.
// A load writes offset and lengths on entry; its twist runs through a second
// chain and the twist trig is written at its end, read there by later computes.
// Synchronous active-low reset clears valid flags only; tables hold junk.
// out_stall freezes the whole pipeline while out_valid is high, in_stall follows it.
`default_nettype none
`include "dh_joint_transform_defines.svh"
module dh_joint_transform #(
  parameter int JOINT_CNT     = dhj_pkg::JOINT_CNT_DEF,
  parameter int CORDIC_STAGES = dhj_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  dhj_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output dhj_pkg::out_item_t out_data
);
  localparam int JW = (JOINT_CNT > 1) ? $clog2(JOINT_CNT) : 1;
  logic en;
  logic [47:0] angle_mem [JOINT_CNT];
  logic [47:0] length_mem [JOINT_CNT];
  dhj_pkg::tag_t t0_r, t0, tc;
  logic signed [15:0] pos_r;
  logic signed [15:0] st, ct;
  logic signed [15:0] s_dummy, c_dummy;
  dhj_pkg::tag_t tl;
  logic [JW-1:0] widx, ridx, tj;
  logic signed [15:0] ca_m, sa_m;
  logic signed [15:0] twist_r;
  dhj_pkg::tag_t tw0;
  dhj_pkg::tag_t p_t_r, p_t_nxt;
  logic signed [15:0] p_st_r, p_ct_r;
  logic signed [31:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [47:0] ax_r, ay_r;
  logic in_ok;
  logic in_vld_r;
  logic [2:0] in_j_r;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign in_ok = (32'(in_data.joint) < JOINT_CNT);
  assign ridx = JW'(in_data.joint);

  // stage 0: table read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_r.vld <= 1'b0;
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_valid;
      t0_r.vld <= in_valid && in_ok;
      t0_r.func <= in_data.func;
      t0_r.joint <= in_data.joint;
      t0_r.neg <= 1'b0;
      in_j_r <= in_data.joint;
      pos_r <= in_data.position;
      twist_r <= in_data.twist;
      t0_r.offset <= angle_mem[ridx][47:32];
      t0_r.ca <= '0;
      t0_r.sa <= '0;
      t0_r.d <= length_mem[ridx][47:24];
      t0_r.a <= length_mem[ridx][23:0];
    end
  end

  // offset and lengths go in on entry; twist trig when its chain finishes,
  // which is before any later compute reaches the end of its own chain
  always_ff @(posedge clk) begin
    if (rst_n && en && in_valid && in_ok && in_data.func == dhj_pkg::FUNC_LOAD) begin
      angle_mem[ridx][47:32] <= in_data.angle_offset;
      length_mem[ridx] <= {in_data.link_offset, in_data.link_length};
    end
    if (rst_n && en && tl.vld) begin
      angle_mem[widx][31:0] <= {c_dummy, s_dummy};
    end
  end
  assign widx = JW'(tl.joint);

  assign t0 = t0_r;
  always_comb begin
    tw0 = t0_r;
    tw0.vld = t0_r.vld && (t0_r.func == dhj_pkg::FUNC_LOAD);
  end

  dhj_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_theta (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ang(17'(t0.offset) + 17'(pos_r)),
    .t_in(t0), .sin_q(st), .cos_q(ct), .t_out(tc)
  );

  dhj_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_twist (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ang(17'(twist_r)),
    .t_in(tw0), .sin_q(s_dummy), .cos_q(c_dummy), .t_out(tl)
  );

  assign tj = JW'(tc.joint);
  assign ca_m = angle_mem[tj][31:16];
  assign sa_m = angle_mem[tj][15:0];

  always_comb begin
    p_t_nxt = tc;
    p_t_nxt.vld = tc.vld && (tc.func == dhj_pkg::FUNC_COMPUTE);
    p_t_nxt.ca = ca_m;
    p_t_nxt.sa = sa_m;
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_t_r.vld <= 1'b0;
    end else if (en) begin
      p_t_r <= p_t_nxt;
      p_st_r <= st;
      p_ct_r <= ct;
      m1_r <= (-32'(st)) * 32'(ca_m);
      m2_r <= 32'(st) * 32'(sa_m);
      m3_r <= 32'(ct) * 32'(ca_m);
      m4_r <= (-32'(ct)) * 32'(sa_m);
      ax_r <= 48'(tc.a) * 48'(ct);
      ay_r <= 48'(tc.a) * 48'(st);
    end
  end

  function automatic logic signed [23:0] rnd_len(input logic signed [47:0] p);
    logic signed [47:0] r;
    r = (p + 48'sd8192) >>> 14;
    if (r > 48'sd8388607) return 24'sh7fffff;
    if (r < -48'sd8388608) return 24'sh800000;
    return r[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p_t_r.vld;
      out_data.joint_out <= p_t_r.joint;
      out_data.r00 <= p_ct_r;
      out_data.r01 <= dhj_pkg::rnd_q14(33'(m1_r));
      out_data.r02 <= dhj_pkg::rnd_q14(33'(m2_r));
      out_data.r10 <= p_st_r;
      out_data.r11 <= dhj_pkg::rnd_q14(33'(m3_r));
      out_data.r12 <= dhj_pkg::rnd_q14(33'(m4_r));
      out_data.r21 <= p_t_r.sa;
      out_data.r22 <= p_t_r.ca;
      out_data.tx <= rnd_len(ax_r);
      out_data.ty <= rnd_len(ay_r);
      out_data.tz <= p_t_r.d;
    end
  end

  `DHJ_ASSERT_IMPL(a_stall_hold, clk, rst_n, out_valid && out_stall, in_stall)
  `DHJ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `DHJ_ASSERT_NEXT(a_bad_joint, clk, rst_n, in_valid && !in_stall && !in_ok, !t0_r.vld)
  `DHJ_ASSERT_IMPL(a_res_compute, clk, rst_n, p_t_r.vld, p_t_r.func == dhj_pkg::FUNC_COMPUTE)
  `DHJ_ASSERT_IMPL(a_entry_vld, clk, rst_n, t0_r.vld, in_vld_r && (32'(in_j_r) < JOINT_CNT))
endmodule
`default_nettype wire
